@@ rtl/bta_pkg.sv @@
// shared types and constants of the boundary tag heap allocator
package bta_pkg;

  localparam int unsigned NEED_W = 12;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_FREED   = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } opcode_e;

  typedef enum logic [4:0] {
    S_INIT0, S_INIT1, S_INIT2, S_IDLE, S_DISP,
    S_A_RD, S_A_CHK, S_A_WH1, S_A_WF1, S_A_WH2, S_A_WF2,
    S_F_RD, S_F_CHK, S_F_NRD, S_F_NCHK, S_F_PRD, S_F_PCHK, S_F_WH, S_F_WF,
    S_EMIT
  } state_e;

  typedef enum logic [2:0] {
    UPD_NONE, UPD_LOAD, UPD_INIT, UPD_STEP, UPD_SPLIT, UPD_NEED, UPD_WHOLE,
    UPD_MNEXT
  } upd_e;

  typedef enum logic [1:0] {
    RD_CUR, RD_NEXT, RD_PREV
  } rd_sel_e;

  typedef struct packed {
    upd_e    upd;
    logic    merge_prev;
    logic    mem_rd;
    rd_sel_e rd_sel;
    logic    mem_wr;
    logic    wr_foot;
    logic    wr_alloc;
    logic    emit;
    logic    emit_addr;
    status_e emit_status;
  } cmd_t;

  typedef struct packed {
    opcode_e op;
    logic    outside;
    logic    misaligned;
    logic    cur_end;
    logic    cur_gt_h;
    logic    cur_eq_h;
    logic    tag_alloc;
    logic    fits;
    logic    split;
    logic    next_in;
    logic    base_nz;
    logic    out_full;
  } sts_t;

endpackage

@@ rtl/bta_datapath.sv @@
// tag memory, walk pointer, block registers and result register
module bta_datapath #(
  parameter int unsigned HEAP_WORDS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bta_pkg::cmd_t     cmd_i,
  output bta_pkg::sts_t     sts_o,
  input  logic              opcode_i,
  input  logic [13:0]       request_bytes_i,
  input  logic [12:0]       payload_offset_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [12:0]       block_address_o,
  output logic [1:0]        status_o
);
  localparam int unsigned AW = (HEAP_WORDS > 1) ? $clog2(HEAP_WORDS) : 1;
  localparam int unsigned CW = $clog2(HEAP_WORDS + 1);
  localparam int unsigned NW = bta_pkg::NEED_W;

  logic [CW:0] mem [HEAP_WORDS];
  logic [CW:0] rd_q;
  logic [CW-1:0] cur_q, cur_d, base_q, base_d, len_q, len_d, h_q, h_d;
  logic [NW-1:0] need_q, need_d;
  bta_pkg::opcode_e op_q, op_d;
  logic outside_q, outside_d, misal_q, misal_d;
  logic out_valid_q;
  logic [12:0] addr_q;
  logic [1:0] status_q;
  logic [CW-1:0] rsz, rd_addr, wr_addr;
  logic ral;
  logic [31:0] payload32;

  assign rsz = rd_q[CW-1:0];
  assign ral = rd_q[CW];

  always_comb begin
    case (cmd_i.rd_sel)
      bta_pkg::RD_NEXT: rd_addr = base_q + len_q;
      bta_pkg::RD_PREV: rd_addr = base_q - CW'(1);
      default:          rd_addr = cur_q;
    endcase
    wr_addr = cmd_i.wr_foot ? (base_q + len_q - CW'(1)) : base_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr) begin
      mem[wr_addr[AW-1:0]] <= {cmd_i.wr_alloc, len_q};
    end
    if (cmd_i.mem_rd) begin
      rd_q <= mem[rd_addr[AW-1:0]];
    end
  end

  always_comb begin
    cur_d = cur_q;  base_d = base_q;  len_d = len_q;  h_d = h_q;
    need_d = need_q;  op_d = op_q;  outside_d = outside_q;  misal_d = misal_q;
    case (cmd_i.upd)
      bta_pkg::UPD_LOAD: begin
        op_d      = bta_pkg::opcode_e'(opcode_i);
        need_d    = NW'((({1'b0, request_bytes_i} + 15'd7) >> 3)) + NW'(2);
        outside_d = (payload_offset_i < 13'd8) ||
                    (32'(payload_offset_i) >= 32'(HEAP_WORDS) * 32'd8);
        misal_d   = payload_offset_i[2:0] != 3'd0;
        h_d       = CW'(32'(payload_offset_i >> 3) - 32'd1);
        cur_d     = '0;
      end
      bta_pkg::UPD_INIT: begin
        base_d = '0;
        len_d  = CW'(HEAP_WORDS);
      end
      bta_pkg::UPD_STEP:  cur_d = cur_q + rsz;
      bta_pkg::UPD_SPLIT: begin
        base_d = cur_q + CW'(need_q);
        len_d  = rsz - CW'(need_q);
      end
      bta_pkg::UPD_NEED: begin
        base_d = cur_q;
        len_d  = CW'(need_q);
      end
      bta_pkg::UPD_WHOLE: begin
        base_d = cur_q;
        len_d  = rsz;
      end
      bta_pkg::UPD_MNEXT: len_d = len_q + rsz;
      default: ;
    endcase
    // merge with the previous block reuses the tag just read
    if (cmd_i.merge_prev) begin
      base_d = base_q - rsz;
      len_d  = len_q + rsz;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;  base_q <= base_d;  len_q <= len_d;  h_q <= h_d;
    need_q <= need_d;  op_q <= op_d;  outside_q <= outside_d;  misal_q <= misal_d;
  end

  assign payload32 = (32'(cur_q) + 32'd1) << 3;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= cmd_i.emit | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      addr_q   <= cmd_i.emit_addr ? payload32[12:0] : 13'd0;
      status_q <= cmd_i.emit_status;
    end
  end

  always_comb begin
    sts_o.op         = op_q;
    sts_o.outside    = outside_q;
    sts_o.misaligned = misal_q;
    sts_o.cur_end    = cur_q == CW'(HEAP_WORDS);
    sts_o.cur_gt_h   = cur_q > h_q;
    sts_o.cur_eq_h   = cur_q == h_q;
    sts_o.tag_alloc  = ral;
    sts_o.fits       = !ral && (32'(rsz) >= 32'(need_q));
    sts_o.split      = (32'(rsz) - 32'(need_q)) >= 32'd2;
    sts_o.next_in    = (32'(base_q) + 32'(len_q)) < 32'(HEAP_WORDS);
    sts_o.base_nz    = base_q != '0;
    sts_o.out_full   = out_valid_q & out_stall_i;
  end

  assign out_valid_o     = out_valid_q;
  assign block_address_o = addr_q;
  assign status_o        = status_q;
endmodule

@@ rtl/bta_controller.sv @@
// sequencer for init, first-fit walk, split and coalescing free
module bta_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bta_pkg::sts_t sts_i,
  output bta_pkg::cmd_t cmd_o
);
  bta_pkg::state_e state_q, state_d;
  bta_pkg::status_e res_q, res_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bta_pkg::S_INIT0;
      res_q   <= bta_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '{upd: bta_pkg::UPD_NONE, merge_prev: 1'b0, mem_rd: 1'b0,
                rd_sel: bta_pkg::RD_CUR, mem_wr: 1'b0, wr_foot: 1'b0,
                wr_alloc: 1'b0, emit: 1'b0, emit_addr: 1'b0,
                emit_status: res_q};
    in_stall_o = state_q != bta_pkg::S_IDLE;
    case (state_q)
      bta_pkg::S_INIT0: begin
        cmd_o.upd = bta_pkg::UPD_INIT;
        state_d   = bta_pkg::S_INIT1;
      end
      bta_pkg::S_INIT1: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = bta_pkg::S_INIT2;
      end
      bta_pkg::S_INIT2: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_foot = 1'b1;
        state_d       = bta_pkg::S_IDLE;
      end
      bta_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.upd = bta_pkg::UPD_LOAD;
          state_d   = bta_pkg::S_DISP;
        end
      end
      bta_pkg::S_DISP: begin
        if (sts_i.op == bta_pkg::OP_ALLOC) begin
          state_d = bta_pkg::S_A_RD;
        end else if (sts_i.outside) begin
          res_d   = bta_pkg::ST_OUTSIDE;
          state_d = bta_pkg::S_EMIT;
        end else if (sts_i.misaligned) begin
          res_d   = bta_pkg::ST_FREED;
          state_d = bta_pkg::S_EMIT;
        end else begin
          state_d = bta_pkg::S_F_RD;
        end
      end
      bta_pkg::S_A_RD: begin
        if (sts_i.cur_end) begin
          res_d   = bta_pkg::ST_NOSPACE;
          state_d = bta_pkg::S_EMIT;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = bta_pkg::S_A_CHK;
        end
      end
      bta_pkg::S_A_CHK: begin
        if (!sts_i.fits) begin
          cmd_o.upd = bta_pkg::UPD_STEP;
          state_d   = bta_pkg::S_A_RD;
        end else if (sts_i.split) begin
          cmd_o.upd = bta_pkg::UPD_SPLIT;
          state_d   = bta_pkg::S_A_WH1;
        end else begin
          cmd_o.upd = bta_pkg::UPD_WHOLE;
          state_d   = bta_pkg::S_A_WH2;
        end
      end
      bta_pkg::S_A_WH1: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = bta_pkg::S_A_WF1;
      end
      bta_pkg::S_A_WF1: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_foot = 1'b1;
        cmd_o.upd     = bta_pkg::UPD_NEED;
        state_d       = bta_pkg::S_A_WH2;
      end
      bta_pkg::S_A_WH2: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_alloc = 1'b1;
        state_d        = bta_pkg::S_A_WF2;
      end
      bta_pkg::S_A_WF2: begin
        cmd_o.mem_wr   = 1'b1;
        cmd_o.wr_alloc = 1'b1;
        cmd_o.wr_foot  = 1'b1;
        res_d          = bta_pkg::ST_OK;
        state_d        = bta_pkg::S_EMIT;
      end
      bta_pkg::S_F_RD: begin
        if (sts_i.cur_gt_h || sts_i.cur_end) begin
          res_d   = bta_pkg::ST_FREED;
          state_d = bta_pkg::S_EMIT;
        end else begin
          cmd_o.mem_rd = 1'b1;
          state_d      = bta_pkg::S_F_CHK;
        end
      end
      bta_pkg::S_F_CHK: begin
        if (!sts_i.cur_eq_h) begin
          cmd_o.upd = bta_pkg::UPD_STEP;
          state_d   = bta_pkg::S_F_RD;
        end else if (!sts_i.tag_alloc) begin
          res_d   = bta_pkg::ST_FREED;
          state_d = bta_pkg::S_EMIT;
        end else begin
          cmd_o.upd = bta_pkg::UPD_WHOLE;
          state_d   = bta_pkg::S_F_NRD;
        end
      end
      bta_pkg::S_F_NRD: begin
        if (sts_i.next_in) begin
          cmd_o.mem_rd = 1'b1;
          cmd_o.rd_sel = bta_pkg::RD_NEXT;
          state_d      = bta_pkg::S_F_NCHK;
        end else begin
          state_d = sts_i.base_nz ? bta_pkg::S_F_PRD : bta_pkg::S_F_WH;
        end
      end
      bta_pkg::S_F_NCHK: begin
        if (!sts_i.tag_alloc) begin
          cmd_o.upd = bta_pkg::UPD_MNEXT;
        end
        state_d = sts_i.base_nz ? bta_pkg::S_F_PRD : bta_pkg::S_F_WH;
      end
      bta_pkg::S_F_PRD: begin
        cmd_o.mem_rd = 1'b1;
        cmd_o.rd_sel = bta_pkg::RD_PREV;
        state_d      = bta_pkg::S_F_PCHK;
      end
      bta_pkg::S_F_PCHK: begin
        cmd_o.merge_prev = !sts_i.tag_alloc;
        state_d          = bta_pkg::S_F_WH;
      end
      bta_pkg::S_F_WH: begin
        cmd_o.mem_wr = 1'b1;
        state_d      = bta_pkg::S_F_WF;
      end
      bta_pkg::S_F_WF: begin
        cmd_o.mem_wr  = 1'b1;
        cmd_o.wr_foot = 1'b1;
        res_d         = bta_pkg::ST_OK;
        state_d       = bta_pkg::S_EMIT;
      end
      bta_pkg::S_EMIT: begin
        if (!sts_i.out_full) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_addr = (res_q == bta_pkg::ST_OK) && (sts_i.op == bta_pkg::OP_ALLOC);
          state_d         = bta_pkg::S_IDLE;
        end
      end
      default: state_d = bta_pkg::S_IDLE;
    endcase
  end
endmodule

@@ rtl/boundary_tag_heap_allocator.sv @@
// top level of the boundary tag heap allocator
// First-fit heap allocator over HEAP_WORDS words of 8 bytes, each block
// framed by a header and a footer tag (size in words, allocated bit) in a
// single-port tag memory. One word is taken at a time while in_stall_o is
// low; the finished result sits in an output register, so a new word can be
// taken while the previous result still waits on out_stall_i. An allocate
// reads one tag per block visited by the first-fit walk, then splits the
// block if it is large enough and writes the tags; a free reads one tag
// per block walked from the heap base up to the freed block, then reads
// the next and previous tags where they lie in the heap and does the two
// tag writes. Rejected frees finish without a walk. The walk is bounded by
// the one read port of the tag memory. After reset the block writes the
// tags of the one free block that spans the heap and stalls input during
// that time; words of the memory that are not current tags are never read,
// so no other clearing is done.
module boundary_tag_heap_allocator #(
  parameter int unsigned HEAP_WORDS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [13:0] request_bytes_i,
  input  logic [12:0] payload_offset_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] block_address_o,
  output logic [1:0]  status_o
);
  bta_pkg::cmd_t cmd;
  bta_pkg::sts_t sts;

  // sequencer
  bta_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // tag memory and registers
  bta_datapath #(
    .HEAP_WORDS (HEAP_WORDS)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .opcode_i         (opcode_i),
    .request_bytes_i  (request_bytes_i),
    .payload_offset_i (payload_offset_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .block_address_o  (block_address_o),
    .status_o         (status_o)
  );

  // a taken word keeps the input stalled in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after accepting a word");

  // only a successful allocate carries an address
  a_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != bta_pkg::ST_OK) |-> block_address_o == 13'd0)
    else $error("address on a failed result");

  // payload addresses are word aligned
  a_addr_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> block_address_o[2:0] == 3'd0)
    else $error("unaligned payload address");
endmodule
